>>> rtl/core/diff_drive_ramped_pwm_core_assert.svh
// Assertion macros for the differential-drive ramped PWM core.
// Taken by `include in the checker; no other dependencies.
`ifndef DIFF_DRIVE_RAMPED_PWM_CORE_ASSERT_SVH
`define DIFF_DRIVE_RAMPED_PWM_CORE_ASSERT_SVH

// Consequent checked in the cycle after the antecedent.
`define DDRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define DDRP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ddrp_pkg.sv
// Shared widths, register indexes, reset values and handshake structs
// for the differential-drive ramped PWM core. No dependencies.
package ddrp_pkg;

    // field widths
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned SPD_W  = 16;
    localparam int unsigned DUTY_W = 12;
    localparam int unsigned PCT_W  = 17;
    localparam int unsigned OFS_W  = 10;
    localparam int unsigned K_W    = 8;
    localparam int unsigned STEP_W = 16;
    localparam int unsigned HWB_W  = 16;

    // serial multiplier: signed A, unsigned B, two B bits per cycle
    localparam int unsigned MA_W   = 34;
    localparam int unsigned MB_W   = 16;
    localparam int unsigned MACC_W = MA_W + 2;
    localparam int unsigned MP_W   = MACC_W + MB_W;
    localparam int unsigned MCNT_W = 3;
    localparam logic [MCNT_W-1:0] FULL_LAST = MCNT_W'(MB_W / 2 - 1);
    localparam logic [MCNT_W-1:0] HALF_LAST = MCNT_W'(MB_W / 4 - 1);

    // slices of a half-length product
    localparam int unsigned Q_W   = 24;   // product >>> 20
    localparam int unsigned SCL_W = 16;   // product >> 8, duty magnitude

    // register indexes
    typedef logic [IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SLEW_STEP        = 3'd0;
    localparam cfg_idx_t CFG_HALF_WHEEL_BASE  = 3'd1;
    localparam cfg_idx_t CFG_SPEED_TO_PERCENT = 3'd2;
    localparam cfg_idx_t CFG_DUTY_OFFSET      = 3'd3;
    localparam cfg_idx_t CFG_DUTY_PER_PERCENT = 3'd4;

    // reset values
    localparam logic [STEP_W-1:0] SLEW_RST = 16'd51200;
    localparam logic [HWB_W-1:0]  HWB_RST  = 16'd8192;
    localparam logic [K_W-1:0]    K_RST    = 8'd35;
    localparam logic [OFS_W-1:0]  OFS_RST  = 10'd50;
    localparam logic [K_W-1:0]    DPP_RST  = 8'd24;

    localparam logic signed [Q_W-1:0]   PCT_LIMIT_Q = 24'sd25600;
    localparam logic signed [PCT_W-1:0] PCT_LIMIT   = 17'sd25600;
    localparam logic [DUTY_W-1:0]       DUTY_MAX    = 12'd4095;

    typedef struct packed {
        logic start;
        logic half;
    } sm_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sm_stat_t;

endpackage

>>> rtl/core/ddrp_sermul.sv
// Radix-4 serial shift-add multiplier: signed A times unsigned B.
// Depends on ddrp_pkg for widths and the control/status structs.
module ddrp_sermul
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ddrp_pkg::sm_ctl_t                   ctl,
    input  logic signed [ddrp_pkg::MA_W-1:0]    a,
    input  logic        [ddrp_pkg::MB_W-1:0]    b,
    output ddrp_pkg::sm_stat_t                  stat,
    output logic        [ddrp_pkg::MP_W-1:0]    product
);

    logic signed [ddrp_pkg::MA_W-1:0]   a_reg;
    logic signed [ddrp_pkg::MACC_W-1:0] acc_reg;
    logic        [ddrp_pkg::MB_W-1:0]   b_reg;
    logic        [ddrp_pkg::MCNT_W-1:0] cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;

    logic        [1:0]                  digit;
    logic signed [ddrp_pkg::MACC_W-1:0] a_ext;
    logic signed [ddrp_pkg::MACC_W-1:0] pp1;
    logic signed [ddrp_pkg::MACC_W-1:0] pp2;
    logic signed [ddrp_pkg::MACC_W-1:0] sum;

    // |acc| stays below |A|, so acc + 3A fits without growth
    always_comb
    begin
        digit = b_reg[1:0];
        a_ext = {{(ddrp_pkg::MACC_W - ddrp_pkg::MA_W){a_reg[ddrp_pkg::MA_W-1]}}, a_reg};
        pp1   = digit[0] ? a_ext : '0;
        pp2   = digit[1] ? (a_ext <<< 1) : '0;
        sum   = acc_reg + pp1 + pp2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.half ? ddrp_pkg::HALF_LAST : ddrp_pkg::FULL_LAST;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg   <= a;
            acc_reg <= '0;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= sum >>> 2;
            b_reg   <= {sum[1:0], b_reg[ddrp_pkg::MB_W-1:2]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = {acc_reg, b_reg};

endmodule

>>> rtl/core/diff_drive_ramped_pwm_core.sv
// Top level of the differential-drive ramped PWM core.
// Depends on ddrp_pkg and two ddrp_sermul instances.
//
// Usage:
//   Input channel (in_valid/in_stall) carries cmd, linear_speed, angular_speed.
//   cmd = 0 sets both wheel targets from the speeds; cmd = 1 is one ramp tick
//   that slews each wheel command toward its target by at most slew_step.
//   Every transfer yields exactly one result transfer on the output channel
//   (out_valid/out_stall): a forward/reverse duty pair per wheel, computed
//   from the present commands.
//   Sequence: a tick goes from the accepting edge through ST_DGO and ST_DUTY
//   to ST_DONE; a set-target item through ST_HW, ST_WHL and ST_DUTY to ST_DONE.
//   No new item is taken until the state is back in ST_IDLE. The work is
//   done by the radix-4 serial multipliers: two bits of the multiplier
//   operand per cycle, 8 steps for half_wheel_base * angular_speed,
//   4 steps each for the percent scaling and the duty scaling.
//   The percent and duty scalings run one wheel per multiplier in parallel.
//   The finished result sits in an output register; while it waits under
//   out_stall the next item is already accepted and worked on, and only the
//   final load waits for the register to drain.
//   Reset: async active low; targets and commands clear to zero, registers
//   take their default values, no result is pending. The user must write
//   configuration (cfg_write/cfg_index/cfg_data) only while idle; not enforced.
module diff_drive_ramped_pwm_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic signed [ddrp_pkg::SPD_W-1:0]    linear_speed,
    input  logic signed [ddrp_pkg::SPD_W-1:0]    angular_speed,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic        [ddrp_pkg::DUTY_W-1:0]   left_duty_forward,
    output logic        [ddrp_pkg::DUTY_W-1:0]   left_duty_reverse,
    output logic        [ddrp_pkg::DUTY_W-1:0]   right_duty_forward,
    output logic        [ddrp_pkg::DUTY_W-1:0]   right_duty_reverse,

    input  logic                                 cfg_write,
    input  ddrp_pkg::cfg_idx_t                   cfg_index,
    input  logic        [ddrp_pkg::CFG_W-1:0]    cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HW,      // half_wheel_base * angular_speed
        ST_WHL,     // wheel sums scaled to percent
        ST_DGO,     // launch duty scaling after a tick
        ST_DUTY,    // command magnitude * duty_per_percent
        ST_DONE     // result ready, waiting for the output register
    } state_t;

    state_t state_reg;

    // configuration
    logic [ddrp_pkg::STEP_W-1:0] slew_step_reg;
    logic [ddrp_pkg::HWB_W-1:0]  half_wheel_base_reg;
    logic [ddrp_pkg::K_W-1:0]    speed_to_percent_reg;
    logic [ddrp_pkg::OFS_W-1:0]  duty_offset_reg;
    logic [ddrp_pkg::K_W-1:0]    duty_per_percent_reg;

    // wheel state, Q8 percent
    logic signed [ddrp_pkg::PCT_W-1:0] left_target_reg;
    logic signed [ddrp_pkg::PCT_W-1:0] right_target_reg;
    logic signed [ddrp_pkg::PCT_W-1:0] left_command_reg;
    logic signed [ddrp_pkg::PCT_W-1:0] right_command_reg;

    logic signed [ddrp_pkg::SPD_W-1:0] v_reg;

    logic                           out_valid_reg;
    logic [ddrp_pkg::DUTY_W-1:0]    lf_reg, lr_reg, rf_reg, rr_reg;

    // multiplier hookup
    ddrp_pkg::sm_ctl_t                  ctl0, ctl1;
    ddrp_pkg::sm_stat_t                 stat0, stat1;
    logic signed [ddrp_pkg::MA_W-1:0]   a0, a1;
    logic        [ddrp_pkg::MB_W-1:0]   b0, b1;
    logic        [ddrp_pkg::MP_W-1:0]   prod0, prod1;

    logic in_accept;
    logic out_free;
    logic start_hw, start_whl, start_duty;

    logic signed [ddrp_pkg::MA_W-1:0]  vs_ext, hw_ext, diff_left, negsum_right;
    logic signed [ddrp_pkg::MA_W-1:0]  mag_left_ext, mag_right_ext;
    logic signed [ddrp_pkg::PCT_W-1:0] left_slewed, right_slewed;
    logic signed [ddrp_pkg::PCT_W-1:0] left_clamped, right_clamped;
    logic        [2*ddrp_pkg::DUTY_W-1:0] left_pair, right_pair;

    function automatic logic signed [ddrp_pkg::PCT_W-1:0] clamp_pct
    (
        input logic signed [ddrp_pkg::Q_W-1:0] q
    );
        logic signed [ddrp_pkg::PCT_W-1:0] r;
        if (q > ddrp_pkg::PCT_LIMIT_Q)
            r = ddrp_pkg::PCT_LIMIT;
        else if (q < -ddrp_pkg::PCT_LIMIT_Q)
            r = -ddrp_pkg::PCT_LIMIT;
        else
            r = q[ddrp_pkg::PCT_W-1:0];
        return r;
    endfunction

    // move c toward t by at most s, never past t
    function automatic logic signed [ddrp_pkg::PCT_W-1:0] slew_cmd
    (
        input logic signed [ddrp_pkg::PCT_W-1:0] c,
        input logic signed [ddrp_pkg::PCT_W-1:0] t,
        input logic        [ddrp_pkg::STEP_W-1:0] s
    );
        logic signed [ddrp_pkg::PCT_W+1:0] c_x, t_x, s_x, up, dn, r;
        c_x = {{2{c[ddrp_pkg::PCT_W-1]}}, c};
        t_x = {{2{t[ddrp_pkg::PCT_W-1]}}, t};
        s_x = {{(ddrp_pkg::PCT_W + 2 - ddrp_pkg::STEP_W){1'b0}}, s};
        up  = c_x + s_x;
        dn  = c_x - s_x;
        if (c_x < t_x)
            r = (up < t_x) ? up : t_x;
        else if (c_x > t_x)
            r = (dn > t_x) ? dn : t_x;
        else
            r = c_x;
        return r[ddrp_pkg::PCT_W-1:0];
    endfunction

    function automatic logic signed [ddrp_pkg::MA_W-1:0] mag_ext
    (
        input logic signed [ddrp_pkg::PCT_W-1:0] c
    );
        logic [ddrp_pkg::PCT_W-1:0] m;
        m = c[ddrp_pkg::PCT_W-1] ? -c : c;
        return {{(ddrp_pkg::MA_W - ddrp_pkg::PCT_W){1'b0}}, m};
    endfunction

    // {forward, reverse}
    function automatic logic [2*ddrp_pkg::DUTY_W-1:0] duty_pair
    (
        input logic signed [ddrp_pkg::PCT_W-1:0] c,
        input logic        [ddrp_pkg::SCL_W-1:0] scaled,
        input logic        [ddrp_pkg::OFS_W-1:0] ofs
    );
        logic [ddrp_pkg::SCL_W:0]    d;
        logic [ddrp_pkg::DUTY_W-1:0] sat, base;
        logic [2*ddrp_pkg::DUTY_W-1:0] r;
        d    = {{(ddrp_pkg::SCL_W + 1 - ddrp_pkg::OFS_W){1'b0}}, ofs}
             + {1'b0, scaled};
        sat  = (d > {{(ddrp_pkg::SCL_W + 1 - ddrp_pkg::DUTY_W){1'b0}}, ddrp_pkg::DUTY_MAX})
             ? ddrp_pkg::DUTY_MAX : d[ddrp_pkg::DUTY_W-1:0];
        base = {{(ddrp_pkg::DUTY_W - ddrp_pkg::OFS_W){1'b0}}, ofs};
        if (c[ddrp_pkg::PCT_W-1])
            r = {base, sat};
        else if (c != '0)
            r = {sat, base};
        else
            r = {base, base};
        return r;
    endfunction

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign start_hw   = in_accept && !cmd;
    assign start_whl  = (state_reg == ST_HW) && stat0.done;
    // set-target goes straight from the wheel products into duty scaling
    assign start_duty = (state_reg == ST_DGO) || ((state_reg == ST_WHL) && stat0.done);

    // wheel sums: v * 2^16 -+ h * w; right side negated before scaling
    always_comb
    begin
        vs_ext = {{(ddrp_pkg::MA_W - ddrp_pkg::SPD_W - 16){v_reg[ddrp_pkg::SPD_W-1]}},
                  v_reg, 16'b0};
        hw_ext = {prod0[32], prod0[32:0]};
        diff_left    = vs_ext - hw_ext;
        negsum_right = -vs_ext - hw_ext;
        mag_left_ext  = mag_ext(left_command_reg);
        mag_right_ext = mag_ext(right_command_reg);
    end

    always_comb
    begin
        a0 = '0;
        b0 = '0;
        a1 = '0;
        b1 = '0;
        if (start_hw)
        begin
            a0 = {{(ddrp_pkg::MA_W - ddrp_pkg::SPD_W){angular_speed[ddrp_pkg::SPD_W-1]}},
                  angular_speed};
            b0 = half_wheel_base_reg;
        end
        else if (start_whl)
        begin
            a0 = diff_left;
            b0 = {{(ddrp_pkg::MB_W - ddrp_pkg::K_W){1'b0}}, speed_to_percent_reg};
            a1 = negsum_right;
            b1 = {{(ddrp_pkg::MB_W - ddrp_pkg::K_W){1'b0}}, speed_to_percent_reg};
        end
        else if (start_duty)
        begin
            a0 = mag_left_ext;
            b0 = {{(ddrp_pkg::MB_W - ddrp_pkg::K_W){1'b0}}, duty_per_percent_reg};
            a1 = mag_right_ext;
            b1 = {{(ddrp_pkg::MB_W - ddrp_pkg::K_W){1'b0}}, duty_per_percent_reg};
        end
    end

    assign ctl0.start = start_hw || start_whl || start_duty;
    assign ctl0.half  = !start_hw;
    assign ctl1.start = start_whl || start_duty;
    assign ctl1.half  = 1'b1;

    ddrp_sermul u_mul_left
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl0),
        .a       (a0),
        .b       (b0),
        .stat    (stat0),
        .product (prod0)
    );

    ddrp_sermul u_mul_right
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl1),
        .a       (a1),
        .b       (b1),
        .stat    (stat1),
        .product (prod1)
    );

    // product >>> 20 is the top slice; floor rounding comes for free
    assign left_clamped  = clamp_pct(prod0[ddrp_pkg::MP_W-1 -: ddrp_pkg::Q_W]);
    assign right_clamped = clamp_pct(prod1[ddrp_pkg::MP_W-1 -: ddrp_pkg::Q_W]);

    assign left_slewed  = slew_cmd(left_command_reg, left_target_reg, slew_step_reg);
    assign right_slewed = slew_cmd(right_command_reg, right_target_reg, slew_step_reg);

    // product >> 8 of a half-length run is the accumulator's low bits
    assign left_pair  = duty_pair(left_command_reg,
                                  prod0[ddrp_pkg::MB_W +: ddrp_pkg::SCL_W], duty_offset_reg);
    assign right_pair = duty_pair(right_command_reg,
                                  prod1[ddrp_pkg::MB_W +: ddrp_pkg::SCL_W], duty_offset_reg);

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                        state_reg <= cmd ? ST_DGO : ST_HW;
                end
                ST_HW:
                begin
                    if (stat0.done)
                        state_reg <= ST_WHL;
                end
                ST_WHL:
                begin
                    if (stat0.done)
                        state_reg <= ST_DUTY;
                end
                ST_DGO:
                begin
                    state_reg <= ST_DUTY;
                end
                ST_DUTY:
                begin
                    if (stat0.done)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            lf_reg <= left_pair[2*ddrp_pkg::DUTY_W-1 -: ddrp_pkg::DUTY_W];
            lr_reg <= left_pair[ddrp_pkg::DUTY_W-1:0];
            rf_reg <= right_pair[2*ddrp_pkg::DUTY_W-1 -: ddrp_pkg::DUTY_W];
            rr_reg <= right_pair[ddrp_pkg::DUTY_W-1:0];
        end
        if (start_hw)
            v_reg <= linear_speed;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slew_step_reg        <= ddrp_pkg::SLEW_RST;
            half_wheel_base_reg  <= ddrp_pkg::HWB_RST;
            speed_to_percent_reg <= ddrp_pkg::K_RST;
            duty_offset_reg      <= ddrp_pkg::OFS_RST;
            duty_per_percent_reg <= ddrp_pkg::DPP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ddrp_pkg::CFG_SLEW_STEP:
                    slew_step_reg <= cfg_data[ddrp_pkg::STEP_W-1:0];
                ddrp_pkg::CFG_HALF_WHEEL_BASE:
                    half_wheel_base_reg <= cfg_data[ddrp_pkg::HWB_W-1:0];
                ddrp_pkg::CFG_SPEED_TO_PERCENT:
                    speed_to_percent_reg <= cfg_data[ddrp_pkg::K_W-1:0];
                ddrp_pkg::CFG_DUTY_OFFSET:
                    duty_offset_reg <= cfg_data[ddrp_pkg::OFS_W-1:0];
                ddrp_pkg::CFG_DUTY_PER_PERCENT:
                    duty_per_percent_reg <= cfg_data[ddrp_pkg::K_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // targets and commands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_target_reg   <= '0;
            right_target_reg  <= '0;
            left_command_reg  <= '0;
            right_command_reg <= '0;
        end
        else
        begin
            if ((state_reg == ST_WHL) && stat0.done)
            begin
                left_target_reg  <= left_clamped;
                right_target_reg <= right_clamped;
            end
            if (in_accept && cmd)
            begin
                left_command_reg  <= left_slewed;
                right_command_reg <= right_slewed;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign left_duty_forward  = lf_reg;
    assign left_duty_reverse  = lr_reg;
    assign right_duty_forward = rf_reg;
    assign right_duty_reverse = rr_reg;

    // the right unit runs in step with the left when started; busy flags not needed
    logic unused_stat;
    assign unused_stat = stat1.busy ^ stat1.done ^ stat0.busy;

endmodule

>>> rtl/core/ddrp_checker.sv
// Port-level checker for diff_drive_ramped_pwm_core, attached by bind.
// Depends on ddrp_pkg and diff_drive_ramped_pwm_core_assert.svh.
`include "diff_drive_ramped_pwm_core_assert.svh"

module ddrp_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [ddrp_pkg::DUTY_W-1:0]       left_duty_forward,
    input logic [ddrp_pkg::DUTY_W-1:0]       left_duty_reverse,
    input logic [ddrp_pkg::DUTY_W-1:0]       right_duty_forward,
    input logic [ddrp_pkg::DUTY_W-1:0]       right_duty_reverse
);

    logic [4*ddrp_pkg::DUTY_W-1:0] duty_all;
    logic                          in_xfer;

    assign duty_all = {left_duty_forward, left_duty_reverse,
                       right_duty_forward, right_duty_reverse};
    assign in_xfer  = in_valid && !in_stall;

    // a waiting result holds until it is taken
    `DDRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(duty_all), "stalled result dropped or changed")

    // the block is busy in the cycle after every transfer in
    `DDRP_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_xfer, in_stall, "input taken twice in a row")

    // a new result appears only as the block returns to idle
    `DDRP_ASSERT_NOW(a_result_idle, clk, rst_n, $rose(out_valid), !in_stall, "result raised while busy")

endmodule

bind diff_drive_ramped_pwm_core ddrp_checker u_ddrp_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .left_duty_forward  (left_duty_forward),
    .left_duty_reverse  (left_duty_reverse),
    .right_duty_forward (right_duty_forward),
    .right_duty_reverse (right_duty_reverse)
);

>>> tb/tb_top.sv
// Self-checking testbench for diff_drive_ramped_pwm_core.
// Predicts wheel targets, slewed commands and bridge duties in-line;
// depends only on ddrp_pkg and the core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ddrp_pkg::*;

    // input item codes
    localparam logic CMD_SET_TARGET = 1'b0;
    localparam logic CMD_TICK       = 1'b1;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned N_PHASES    = 12;
    localparam int unsigned PHASE_ITEMS = 160;
    localparam int unsigned DRAIN_WAIT  = 40;   // outlasts one set-target item
    localparam int unsigned N_DIRECTED  = 23;

    typedef struct packed {
        logic [DUTY_W-1:0] left_fwd;
        logic [DUTY_W-1:0] left_rev;
        logic [DUTY_W-1:0] right_fwd;
        logic [DUTY_W-1:0] right_rev;
    } duty_set_t;

    // one directed transfer; fixed_duty is used only when has_fixed is set
    typedef struct packed {
        logic              c;
        logic [SPD_W-1:0]  lin;
        logic [SPD_W-1:0]  ang;
        logic              has_fixed;
        duty_set_t         fixed_duty;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       cmd;
    logic signed [SPD_W-1:0]    linear_speed;
    logic signed [SPD_W-1:0]    angular_speed;
    logic                       out_valid;
    logic                       out_stall;
    logic        [DUTY_W-1:0]   left_duty_forward;
    logic        [DUTY_W-1:0]   left_duty_reverse;
    logic        [DUTY_W-1:0]   right_duty_forward;
    logic        [DUTY_W-1:0]   right_duty_reverse;
    logic                       cfg_write;
    cfg_idx_t                   cfg_index;
    logic        [CFG_W-1:0]    cfg_data;

    // register shadows, reset values from the package
    logic [STEP_W-1:0]          slew_sh = SLEW_RST;
    logic [HWB_W-1:0]           hwb_sh  = HWB_RST;
    logic [K_W-1:0]             k_sh    = K_RST;
    logic [OFS_W-1:0]           ofs_sh  = OFS_RST;
    logic [K_W-1:0]             dpp_sh  = DPP_RST;

    // wheel state, Q8 percent
    logic signed [PCT_W-1:0]    tgt_left  = '0;
    logic signed [PCT_W-1:0]    tgt_right = '0;
    logic signed [PCT_W-1:0]    drv_left  = '0;
    logic signed [PCT_W-1:0]    drv_right = '0;

    duty_set_t                  pending_duties [$];
    duty_set_t                  want_duty;

    int unsigned                tx_idle_pct  = 10;
    int unsigned                rx_stall_pct = 81;
    int unsigned                err_cnt      = 0;
    int unsigned                n_set        = 0;
    int unsigned                n_tick       = 0;
    int unsigned                n_checked    = 0;
    int unsigned                n_cfg        = 0;
    int unsigned                cycles       = 0;

    // Directed part. Rows with a typed duty set are the ones that follow
    // straight from reset values: full-scale speeds clamp to +-100 %, the
    // default step reaches the clamp in one tick, 100 % * 24 / 1 % = 2400.
    stim_row_t dir_rows [N_DIRECTED] = '{
        '{CMD_SET_TARGET, 16'h0000, 16'h0000, 1'b1, '{12'd50,   12'd50,   12'd50,   12'd50}},
        '{CMD_TICK,       16'h0000, 16'h0000, 1'b1, '{12'd50,   12'd50,   12'd50,   12'd50}},
        '{CMD_SET_TARGET, 16'h7fff, 16'h0000, 1'b1, '{12'd50,   12'd50,   12'd50,   12'd50}},
        '{CMD_TICK,       16'h0000, 16'h0000, 1'b1, '{12'd2450, 12'd50,   12'd50,   12'd2450}},
        '{CMD_SET_TARGET, 16'h8000, 16'h0000, 1'b1, '{12'd2450, 12'd50,   12'd50,   12'd2450}},
        '{CMD_TICK,       16'h0000, 16'h0000, 1'b1, '{12'd50,   12'd2450, 12'd2450, 12'd50}},
        '{CMD_SET_TARGET, 16'h0000, 16'h7fff, 1'b0, '0},
        '{CMD_TICK,       16'h0000, 16'h0000, 1'b0, '0},
        '{CMD_SET_TARGET, 16'h0000, 16'h8000, 1'b0, '0},
        '{CMD_TICK,       16'h0000, 16'h0000, 1'b0, '0},
        // -1 LSB on both: floor rounding of a small negative product
        '{CMD_SET_TARGET, 16'hffff, 16'hffff, 1'b0, '0},
        '{CMD_TICK,       16'h0000, 16'h0000, 1'b0, '0},
        '{CMD_SET_TARGET, 16'h0001, 16'h0000, 1'b0, '0},
        // speed fields on a tick are don't-care
        '{CMD_TICK,       16'h7fff, 16'h8000, 1'b0, '0},
        '{CMD_SET_TARGET, 16'h7fff, 16'h7fff, 1'b0, '0},
        '{CMD_TICK,       16'h8000, 16'h7fff, 1'b0, '0},
        '{CMD_SET_TARGET, 16'h8000, 16'h7fff, 1'b0, '0},
        '{CMD_TICK,       16'hffff, 16'hffff, 1'b0, '0},
        '{CMD_SET_TARGET, 16'h8000, 16'h8000, 1'b0, '0},
        '{CMD_TICK,       16'h0000, 16'h0000, 1'b0, '0},
        '{CMD_TICK,       16'hffff, 16'hffff, 1'b0, '0},
        '{CMD_SET_TARGET, 16'h0000, 16'h0000, 1'b0, '0},
        '{CMD_TICK,       16'h0000, 16'h0000, 1'b0, '0}
    };

    diff_drive_ramped_pwm_core u_dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .cmd                (cmd),
        .linear_speed       (linear_speed),
        .angular_speed      (angular_speed),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .left_duty_forward  (left_duty_forward),
        .left_duty_reverse  (left_duty_reverse),
        .right_duty_forward (right_duty_forward),
        .right_duty_reverse (right_duty_reverse),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Q28 percent -> Q8 percent, floor, then clamp to +-100 %
    function automatic logic signed [PCT_W-1:0] clamp_percent(longint q28);
        longint q;
        q = q28 >>> 20;
        if (q > longint'(PCT_LIMIT))
            return PCT_LIMIT;
        if (q < -longint'(PCT_LIMIT))
            return -PCT_LIMIT;
        return q[PCT_W-1:0];
    endfunction

    function automatic logic signed [PCT_W-1:0] slew_toward(logic signed [PCT_W-1:0] c,
                                                            logic signed [PCT_W-1:0] t);
        int cc;
        int tt;
        int s;
        cc = c;
        tt = t;
        s  = int'(slew_sh);
        if (cc < tt)
            cc = (cc + s < tt) ? cc + s : tt;
        if (cc > tt)
            cc = (cc - s > tt) ? cc - s : tt;
        return cc[PCT_W-1:0];
    endfunction

    function automatic logic [DUTY_W-1:0] sat_duty(int x);
        return (x > int'(DUTY_MAX)) ? DUTY_MAX : x[DUTY_W-1:0];
    endfunction

    // sign of the command picks the driven side; the other gets the offset
    function automatic void bridge_duty(input  logic signed [PCT_W-1:0] c,
                                        output logic [DUTY_W-1:0]       fwd,
                                        output logic [DUTY_W-1:0]       rev);
        int ci;
        int mag;
        int d;
        ci  = c;
        mag = (ci < 0) ? -ci : ci;
        d   = int'(ofs_sh) + ((mag * int'(dpp_sh)) >>> 8);
        fwd = sat_duty((ci > 0) ? d : int'(ofs_sh));
        rev = sat_duty((ci < 0) ? d : int'(ofs_sh));
    endfunction

    function automatic duty_set_t predict_duties(logic c,
                                                 logic signed [SPD_W-1:0] lin,
                                                 logic signed [SPD_W-1:0] ang);
        duty_set_t r;
        longint    v;
        longint    hw;
        longint    k;
        if (c == CMD_SET_TARGET)
        begin
            v  = longint'(lin) * 65536;
            hw = longint'(hwb_sh) * longint'(ang);
            k  = longint'(k_sh);
            tgt_left  = clamp_percent((v - hw) * k);
            tgt_right = clamp_percent(-((v + hw) * k));
        end
        else
        begin
            drv_left  = slew_toward(drv_left, tgt_left);
            drv_right = slew_toward(drv_right, tgt_right);
        end
        bridge_duty(drv_left,  r.left_fwd,  r.left_rev);
        bridge_duty(drv_right, r.right_fwd, r.right_rev);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Drive one input transfer; inputs move on the falling edge, and
    // in_valid stays high from one item to the next unless an idle is drawn.
    task automatic send_item(input logic c, input logic [SPD_W-1:0] lin,
                             input logic [SPD_W-1:0] ang,
                             input logic has_fixed, input duty_set_t fixed_duty);
        duty_set_t d;
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        cmd           = c;
        linear_speed  = lin;
        angular_speed = ang;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge: advance the predictor
        d = predict_duties(c, lin, ang);
        pending_duties.push_back(has_fixed ? fixed_duty : d);
        if (c == CMD_SET_TARGET)
            n_set++;
        else
            n_tick++;
    endtask

    // Register write; the shadow copy masks to the register width.
    task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            CFG_SLEW_STEP:        slew_sh = data[STEP_W-1:0];
            CFG_HALF_WHEEL_BASE:  hwb_sh  = data[HWB_W-1:0];
            CFG_SPEED_TO_PERCENT: k_sh    = data[K_W-1:0];
            CFG_DUTY_OFFSET:      ofs_sh  = data[OFS_W-1:0];
            CFG_DUTY_PER_PERCENT: dpp_sh  = data[K_W-1:0];
            default:              ;
        endcase
        n_cfg++;
    endtask

    // Per-phase setting: phase 0 maxima but the step (duty saturation),
    // phase 1 all zero (frozen commands, zero targets), phase 2 the
    // smallest nonzero step, the rest random with mostly slow ramps.
    // Narrow registers get junk in the unused upper data bits.
    task automatic configure_phase(input int unsigned p);
        logic [STEP_W-1:0] s;
        logic [HWB_W-1:0]  h;
        logic [K_W-1:0]    k;
        logic [OFS_W-1:0]  o;
        logic [K_W-1:0]    dp;
        case (p)
            0:
            begin
                s = 16'd51200; h = 16'hffff; k = 8'hff; o = 10'h3ff; dp = 8'hff;
            end
            1:
            begin
                s = '0; h = '0; k = '0; o = '0; dp = '0;
            end
            2:
            begin
                s = 16'd1; h = HWB_RST; k = K_RST; o = OFS_RST; dp = DPP_RST;
            end
            default:
            begin
                s  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 51200))
                                                 : 16'($urandom_range(1, 3000));
                h  = 16'($urandom);
                k  = 8'($urandom);
                o  = 10'($urandom);
                dp = 8'($urandom);
            end
        endcase
        write_register(CFG_SLEW_STEP, s);
        write_register(CFG_HALF_WHEEL_BASE, h);
        write_register(CFG_SPEED_TO_PERCENT, {8'($urandom), k});
        write_register(CFG_DUTY_OFFSET, {6'($urandom), o});
        write_register(CFG_DUTY_PER_PERCENT, {8'($urandom), dp});
        // index past the register list must be ignored
        if (p % 3 == 0)
            write_register(cfg_idx_t'(CFG_DUTY_PER_PERCENT + 1 + $urandom_range(0, 2)),
                           16'($urandom));
    endtask

    // Mix of full-range, moderate (mostly unclamped) and corner speeds.
    function automatic logic [SPD_W-1:0] rand_speed();
        case ($urandom_range(0, 3))
            0, 1:    return 16'($urandom);
            2:       return 16'($urandom_range(0, 4000) - 2000);
            default:
                case ($urandom_range(0, 3))
                    0:       return 16'h7fff;
                    1:       return 16'h8000;
                    2:       return 16'hffff;
                    default: return 16'h0000;
                endcase
        endcase
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_duties.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, checks on every accepted transfer
    // ------------------------------------------------------------------

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    function automatic void check_duty(string field, logic [DUTY_W-1:0] want,
                                       logic [DUTY_W-1:0] got);
        if (got !== want)
        begin
            err_cnt++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_duties.size() == 0)
            begin
                err_cnt++;
                $display("%0t ns: unexpected result transfer, expected none, got %0d/%0d/%0d/%0d",
                         $time, left_duty_forward, left_duty_reverse,
                         right_duty_forward, right_duty_reverse);
            end
            else
            begin
                want_duty = pending_duties.pop_front();
                check_duty("left_duty_forward",  want_duty.left_fwd,  left_duty_forward);
                check_duty("left_duty_reverse",  want_duty.left_rev,  left_duty_reverse);
                check_duty("right_duty_forward", want_duty.right_fwd, right_duty_forward);
                check_duty("right_duty_reverse", want_duty.right_rev, right_duty_reverse);
                n_checked++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_duties.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = CMD_SET_TARGET;
        linear_speed  = '0;
        angular_speed = '0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_SLEW_STEP;
        cfg_data      = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed transfers at reset register values
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(dir_rows[i].c, dir_rows[i].lin, dir_rows[i].ang,
                      dir_rows[i].has_fixed, dir_rows[i].fixed_duty);
        wait_drained();

        // random phases; idle profile changes every third of the run
        for (int unsigned p = 0; p < N_PHASES; p++)
        begin
            case (p * 3 / N_PHASES)
                0:       begin tx_idle_pct = 10; rx_stall_pct = 81; end
                1:       begin tx_idle_pct = 81; rx_stall_pct = 10; end
                default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            endcase
            configure_phase(p);
            // mostly ticks so commands ramp across several transfers
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(CMD_SET_TARGET, rand_speed(), rand_speed(), 1'b0, '0);
                else
                    send_item(CMD_TICK, 16'($urandom), 16'($urandom), 1'b0, '0);
            end
            wait_drained();
        end

        // catch any stray late result
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("summary: %0d set-target and %0d tick transfers, %0d register writes",
                 n_set, n_tick, n_cfg);
        $display("summary: %0d results checked over %0d register settings, %0d errors",
                 n_checked, N_PHASES + 1, err_cnt);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
